@@ src/hws_pkg.sv @@
// shared constants, types and the hash reduction table for the hashed word set
package hws_pkg;

    localparam int BUCKET_COUNT = 3001;
    localparam int POOL_ENTRIES = 4096;
    localparam int WORD_CHARS   = 5;

    localparam int WORD_W   = 8 * WORD_CHARS;
    localparam int BUCKET_W = 12;
    localparam int HEAD_AW  = $clog2(BUCKET_COUNT);
    localparam int ENTRY_AW = $clog2(POOL_ENTRIES);
    localparam int LINK_W   = $clog2(POOL_ENTRIES + 1);
    localparam int CHAR_CW  = $clog2(WORD_CHARS + 1);

    localparam int HASH_SEED = 5381;
    localparam int HASH_MULT = 33;
    localparam int HASH_INIT = HASH_SEED % BUCKET_COUNT;

    localparam int P_MAX      = (BUCKET_COUNT - 1) * HASH_MULT + 255;
    localparam int P_W        = $clog2(P_MAX + 1);
    localparam int RED_SHIFT  = $clog2(BUCKET_COUNT) - 1;
    localparam int RED_DEPTH  = 2 ** (P_W - RED_SHIFT);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [WORD_W-1:0]  word;
        logic [HEAD_AW-1:0] bucket;
    } t_job;

    typedef struct packed {
        logic                found;
        logic                status;
        logic [BUCKET_W-1:0] bucket;
    } t_result;

    typedef logic [P_W-1:0] t_red_tab [RED_DEPTH];

    // largest multiple of the bucket count at or below each coarse step
    function automatic t_red_tab red_table();
        t_red_tab t;
        for (int i = 0; i < RED_DEPTH; i++) begin
            t[i] = P_W'(((i * (2 ** RED_SHIFT)) / BUCKET_COUNT) * BUCKET_COUNT);
        end
        return t;
    endfunction

    localparam t_red_tab RED_TAB = red_table();

endpackage

@@ src/hws_ram.sv @@
// generic single write port ram with registered read
module hws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/hws_front.sv @@
// front end: accepts beats, normalizes the word and computes its bucket
module hws_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_stall,
    input  logic                 i_mode,
    input  logic [hws_pkg::WORD_W-1:0] i_word,
    output logic                 o_full,
    output logic                 o_job_valid,
    output hws_pkg::t_job        o_job,
    input  logic                 i_job_full
);
    import hws_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_RED, F_OUT} t_fstate;

    t_fstate             r_state;
    logic                r_mode;
    logic [WORD_W-1:0]   r_word;
    logic [WORD_W-1:0]   r_shift;
    logic [HEAD_AW-1:0]  r_h;
    logic [P_W-1:0]      r_p;
    logic [CHAR_CW-1:0]  r_left;

    logic [7:0]          cur_byte;
    logic [P_W-1:0]      n_p;
    logic [P_W-1:0]      diff;
    logic [HEAD_AW-1:0]  n_h;
    logic [WORD_W-1:0]   norm_word;

    function automatic logic [WORD_W-1:0] normalize(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        logic              ended;
        r     = '0;
        ended = 1'b0;
        for (int i = WORD_CHARS - 1; i >= 0; i--) begin
            if (w[8*i +: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                r[8*i +: 8] = w[8*i +: 8];
            end
        end
        return r;
    endfunction

    assign norm_word = normalize(i_word);
    assign cur_byte  = r_shift[WORD_W-1 -: 8];
    assign n_p       = P_W'(r_h) * P_W'(HASH_MULT) + P_W'(cur_byte);
    assign diff      = r_p - RED_TAB[r_p[P_W-1:RED_SHIFT]];
    assign n_h       = (diff >= P_W'(BUCKET_COUNT)) ? HEAD_AW'(diff - P_W'(BUCKET_COUNT))
                                                    : HEAD_AW'(diff);

    assign o_full      = (r_state != F_IDLE) || i_stall;
    assign o_job_valid = (r_state == F_OUT);
    assign o_job       = '{mode: r_mode, word: r_word, bucket: r_h};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_push && !i_stall) begin
                        r_mode  <= i_mode;
                        r_word  <= norm_word;
                        r_shift <= norm_word;
                        r_h     <= HEAD_AW'(HASH_INIT);
                        r_left  <= CHAR_CW'(WORD_CHARS);
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    if (r_left == '0 || cur_byte == 8'd0) begin
                        r_state <= F_OUT;
                    end else begin
                        r_p     <= n_p;
                        r_state <= F_RED;
                    end
                end
                F_RED: begin
                    r_h     <= n_h;
                    r_shift <= r_shift << 8;
                    r_left  <= r_left - 1'b1;
                    r_state <= F_MUL;
                end
                F_OUT: begin
                    if (!i_job_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

@@ src/hws_queue.sv @@
// short job queue between the front end and the table engine
module hws_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hws_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output hws_pkg::t_job o_data,
    output logic          o_empty
);
    import hws_pkg::*;

    t_job                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
        end
    end

endmodule

@@ src/hws_back.sv @@
// table engine: clears the bucket heads, inserts entries and walks chains
module hws_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  hws_pkg::t_job    i_job,
    output logic             o_job_pop,
    output logic             o_clearing,
    output hws_pkg::t_result o_result,
    output logic             o_empty,
    input  logic             i_pop
);
    import hws_pkg::*;

    typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_HEAD, B_WALK, B_DONE} t_bstate;

    t_bstate             r_state;
    logic [HEAD_AW-1:0]  r_clr_idx;
    logic [LINK_W-1:0]   r_used;
    logic [LINK_W-1:0]   r_steps;
    t_job                r_job;
    logic                r_found;
    logic                r_status;
    t_result             r_out;
    logic                r_out_valid;

    logic                   head_we;
    logic [HEAD_AW-1:0]     head_waddr;
    logic [LINK_W-1:0]      head_wdata;
    logic [LINK_W-1:0]      head_rdata;
    logic                   ent_we;
    logic [WORD_W+LINK_W-1:0] ent_wdata;
    logic [WORD_W+LINK_W-1:0] ent_rdata;
    logic [ENTRY_AW-1:0]    ent_raddr;
    logic [WORD_W-1:0]      ent_word;
    logic [LINK_W-1:0]      ent_link;
    logic [LINK_W-1:0]      ptr;
    logic [LINK_W-1:0]      n_steps;
    logic                   walk_stop;
    logic                   out_free;

    assign ent_word  = ent_rdata[WORD_W+LINK_W-1:LINK_W];
    assign ent_link  = ent_rdata[LINK_W-1:0];
    assign ptr       = (r_state == B_HEAD) ? head_rdata : ent_link;
    assign n_steps   = (r_state == B_HEAD) ? r_steps : r_steps + 1'b1;
    assign walk_stop = (ptr == '0) || (n_steps >= r_used) ||
                       (ptr > LINK_W'(POOL_ENTRIES));
    assign ent_raddr = ENTRY_AW'(ptr - 1'b1);

    assign head_we    = (r_state == B_CLEAR) ||
                        (r_state == B_HEAD && r_job.mode == MODE_INSERT);
    assign head_waddr = (r_state == B_CLEAR) ? r_clr_idx : r_job.bucket;
    assign head_wdata = (r_state == B_CLEAR) ? '0 : r_used + 1'b1;
    assign ent_we     = (r_state == B_HEAD && r_job.mode == MODE_INSERT);
    assign ent_wdata  = {r_job.word, head_rdata};

    assign o_job_pop  = (r_state == B_IDLE) && i_job_valid;
    assign o_clearing = (r_state == B_CLEAR);
    assign o_result   = r_out;
    assign o_empty    = !r_out_valid;
    assign out_free   = !r_out_valid || i_pop;

    hws_ram #(.WIDTH(LINK_W), .DEPTH(BUCKET_COUNT)) u_heads (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (i_job.bucket),
        .o_rdata (head_rdata)
    );

    hws_ram #(.WIDTH(WORD_W + LINK_W), .DEPTH(POOL_ENTRIES)) u_entries (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_used[ENTRY_AW-1:0]),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_idx   <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_pop && r_state != B_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    if (r_clr_idx == HEAD_AW'(BUCKET_COUNT - 1)) begin
                        r_state <= B_IDLE;
                    end else begin
                        r_clr_idx <= r_clr_idx + 1'b1;
                    end
                end
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job    <= i_job;
                        r_found  <= 1'b0;
                        r_status <= 1'b0;
                        r_steps  <= '0;
                        if (i_job.mode == MODE_INSERT &&
                            r_used >= LINK_W'(POOL_ENTRIES)) begin
                            r_status <= 1'b1;
                            r_state  <= B_DONE;
                        end else begin
                            r_state <= B_HEAD;
                        end
                    end
                end
                B_HEAD: begin
                    if (r_job.mode == MODE_INSERT) begin
                        r_used  <= r_used + 1'b1;
                        r_state <= B_DONE;
                    end else if (walk_stop) begin
                        r_state <= B_DONE;
                    end else begin
                        r_state <= B_WALK;
                    end
                end
                B_WALK: begin
                    if (ent_word == r_job.word) begin
                        r_found <= 1'b1;
                        r_state <= B_DONE;
                    end else if (walk_stop) begin
                        r_state <= B_DONE;
                    end else begin
                        r_steps <= n_steps;
                    end
                end
                B_DONE: begin
                    if (out_free) begin
                        r_out       <= '{found: r_found, status: r_status,
                                         bucket: BUCKET_W'(r_job.bucket)};
                        r_out_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= LINK_W'(POOL_ENTRIES))
        else $error("entry count beyond pool");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !o_job_pop)
        else $error("job taken during head clearing");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_HEAD && r_job.mode == MODE_INSERT) |=>
            (r_used == LINK_W'($past(r_used) + 1'b1)))
        else $error("insert did not advance entry count");

    a_status_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status) |-> !r_out.found)
        else $error("refused insert reports found");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop && r_state != B_CLEAR) |=> (r_out_valid && $stable(r_out)))
        else $error("waiting result lost");

endmodule

@@ src/hashed_word_set_core.sv @@
// top level of the hashed word set: front end, job queue and table engine
//
// input channel: i_push / o_full carry one beat of i_mode and i_word. mode 0
// inserts the word at the head of its bucket chain (duplicates kept), mode 1
// looks it up. bytes after the first zero byte are ignored.
// result channel: o_empty / i_pop; one result beat per input beat, in order,
// with o_found, o_status (1 when an insert is refused, pool full) and o_bucket.
// the front end hashes one character at a time, a multiply step then a
// reduce step (F_MUL, F_RED), and takes no new beat until it has handed its
// job to the queue; the table engine handles an insert through B_HEAD and
// B_DONE (B_HEAD skipped when refused) and a lookup through B_HEAD and one
// B_WALK step per chain entry visited, each step waiting on the registered
// read of the entry memory. the two parts overlap through a two-deep job
// queue, so the slower of the two sets the rate. after reset the bucket head
// memory is cleared one entry per cycle, all 3001 entries, and o_full stays
// high meanwhile. a stalled receiver leaves the result in the output
// register; one more job can finish in the engine and wait, two more wait in
// the queue and one more in the front end, which keeps o_full high until the
// receiver takes a beat.
module hashed_word_set_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_mode,
    input  logic [hws_pkg::WORD_W-1:0]   i_word,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_found,
    output logic        o_status,
    output logic [hws_pkg::BUCKET_W-1:0] o_bucket
);
    import hws_pkg::*;

    logic    front_valid;
    t_job    front_job;
    logic    q_full;
    logic    q_empty;
    t_job    q_job;
    logic    job_pop;
    logic    clearing;
    t_result result;

    hws_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_stall     (clearing),
        .i_mode      (i_mode),
        .i_word      (i_word),
        .o_full      (o_full),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_full  (q_full)
    );

    hws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (job_pop),
        .o_data  (q_job),
        .o_empty (q_empty)
    );

    hws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (q_job),
        .o_job_pop   (job_pop),
        .o_clearing  (clearing),
        .o_result    (result),
        .o_empty     (o_empty),
        .i_pop       (i_pop)
    );

    assign o_found  = result.found;
    assign o_status = result.status;
    assign o_bucket = result.bucket;

endmodule
